// ===== rtl/core/hdmc_pkg.sv =====
// ----------------------------------------------------------------------------
// hdmc_pkg
// Shared types and constants for the hashed direct-mapped block cache.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hdmc_pkg;

    // Field widths fixed by the request format
    localparam int KEY_BITS      = 31;
    localparam int DATA_PORT_W   = 64;
    localparam int HASH_W        = 32;

    // Multiplicative hash factor
    localparam logic [HASH_W-1:0] HASH_FACTOR = 32'd754343;

    // Request type codes
    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_STORE  = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clear_we;   // write an empty entry during the clearing pass
        logic load;       // capture the incoming request
        logic mul;        // hash product
        logic absv;       // magnitude of the product
        logic qest;       // quotient estimate
        logic rem;        // partial remainder
        logic fix;        // final slot index
        logic rd;         // memory read of the slot
        logic finish;     // load the response, write back on a store
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clear_last; // clearing pass is at its last entry
    } sts_t;

endpackage

// ===== rtl/core/hdmc_ctrl.sv =====
// ----------------------------------------------------------------------------
// hdmc_ctrl
// Sequencer for the block cache: clearing pass, hash steps, slot access.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hdmc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  hdmc_pkg::sts_t    sts,
    output hdmc_pkg::cmd_t    cmd
);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_MUL   = 4'd2;
    localparam logic [3:0] ST_ABS   = 4'd3;
    localparam logic [3:0] ST_QEST  = 4'd4;
    localparam logic [3:0] ST_REM   = 4'd5;
    localparam logic [3:0] ST_FIX   = 4'd6;
    localparam logic [3:0] ST_READ  = 4'd7;
    localparam logic [3:0] ST_RESP  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_we = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ABS;
            end
            ST_ABS:
            begin
                cmd.absv   = 1'b1;
                state_next = ST_QEST;
            end
            ST_QEST:
            begin
                cmd.qest   = 1'b1;
                state_next = ST_REM;
            end
            ST_REM:
            begin
                cmd.rem    = 1'b1;
                state_next = ST_FIX;
            end
            ST_FIX:
            begin
                cmd.fix    = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/core/hdmc_dp.sv =====
// ----------------------------------------------------------------------------
// hdmc_dp
// Datapath: slot hash, reduction modulo the slot count, slot memory, response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hdmc_dp #(
    parameter int TABLE_SLOTS = 301,
    parameter int DATA_BITS   = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  hdmc_pkg::cmd_t                     cmd,
    output hdmc_pkg::sts_t                     sts,
    input  logic                               req_type,
    input  logic [hdmc_pkg::KEY_BITS-1:0]      block_number,
    input  logic [hdmc_pkg::DATA_PORT_W-1:0]   block_data,
    output logic                               hit,
    output logic [hdmc_pkg::DATA_PORT_W-1:0]   read_data,
    output logic                               replaced_other
);

    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int HW     = hdmc_pkg::HASH_W;
    localparam int KW     = hdmc_pkg::KEY_BITS;
    localparam int WORD_W = 1 + KW + DATA_BITS;
    localparam logic [HW-1:0] SLOTS_C = HW'(TABLE_SLOTS);
    // floor(2^32 / slots): quotient estimate is short by at most one
    localparam logic [63:0] RECIP_WIDE = (64'd1 << HW) / 64'(TABLE_SLOTS);
    localparam logic [HW-1:0] RECIP = RECIP_WIDE[HW-1:0];
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

    // Request registers
    logic                 store_reg;
    logic [KW-1:0]        key_reg;
    logic [DATA_BITS-1:0] data_reg;

    // Hash pipeline registers
    logic [HW-1:0]        prod_reg;
    logic [HW-1:0]        mag_reg;
    logic [HW-1:0]        q_reg;
    logic [HW-1:0]        rem_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic [SLOT_W-1:0]    clr_cnt_reg;
    logic [SLOT_W-1:0]    clr_cnt_next;

    // Slot memory: {valid, tag, data}
    logic [WORD_W-1:0]    mem [TABLE_SLOTS];
    logic [WORD_W-1:0]    rd_word_reg;
    logic                 mem_we;
    logic [SLOT_W-1:0]    mem_waddr;
    logic [WORD_W-1:0]    mem_wdata;

    logic [63:0]          qmul;
    logic [HW-1:0]        rem_next;
    logic [HW-1:0]        slot_full;
    logic                 e_valid;
    logic [KW-1:0]        e_tag;
    logic [DATA_BITS-1:0] e_data;
    logic                 tag_eq;

    // Clearing pass counter
    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        if (cmd.clear_we && !sts.clear_last)
        begin
            clr_cnt_next = clr_cnt_reg + SLOT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    assign sts.clear_last = (clr_cnt_reg == LAST_SLOT);

    // Reduction arithmetic
    assign qmul      = 64'(mag_reg) * 64'(RECIP);
    assign rem_next  = mag_reg - HW'(q_reg * SLOTS_C);
    assign slot_full = (rem_reg >= SLOTS_C) ? (rem_reg - SLOTS_C) : rem_reg;

    // Request capture and hash steps
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            store_reg <= (req_type == hdmc_pkg::REQ_STORE);
            key_reg   <= block_number;
            data_reg  <= block_data[DATA_BITS-1:0];
        end
        if (cmd.mul)
        begin
            prod_reg <= HW'({1'b0, key_reg}) * hdmc_pkg::HASH_FACTOR;
        end
        if (cmd.absv)
        begin
            mag_reg <= prod_reg[HW-1] ? (HW'(0) - prod_reg) : prod_reg;
        end
        if (cmd.qest)
        begin
            q_reg <= qmul[63:HW];
        end
        if (cmd.rem)
        begin
            rem_reg <= rem_next;
        end
        if (cmd.fix)
        begin
            slot_reg <= slot_full[SLOT_W-1:0];
        end
    end

    // Memory write port: clearing pass or store
    assign mem_we    = cmd.clear_we || (cmd.finish && store_reg);
    assign mem_waddr = cmd.clear_we ? clr_cnt_reg : slot_reg;
    assign mem_wdata = cmd.clear_we ? '0 : {1'b1, key_reg, data_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            rd_word_reg <= mem[slot_reg];
        end
    end

    // Entry compare
    assign e_valid = rd_word_reg[WORD_W-1];
    assign e_tag   = rd_word_reg[DATA_BITS +: KW];
    assign e_data  = rd_word_reg[DATA_BITS-1:0];
    assign tag_eq  = (e_tag == key_reg);

    // Response registers
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            hit            <= e_valid && tag_eq;
            replaced_other <= store_reg && e_valid && !tag_eq;
            if (!store_reg && e_valid && tag_eq)
            begin
                read_data <= hdmc_pkg::DATA_PORT_W'(e_data);
            end
            else
            begin
                read_data <= '0;
            end
        end
    end

endmodule

// ===== rtl/core/hashed_direct_mapped_block_cache_core.sv =====
// ----------------------------------------------------------------------------
// hashed_direct_mapped_block_cache_core
// Direct-mapped cache of disk blocks, slot chosen by a multiplicative hash.
// After acceptance each request passes through the hash steps (product,
// magnitude, reciprocal multiply, remainder, final correction), then the
// registered slot memory read and the compare/write-back, which waits while
// the output register is full. A new request is accepted once the previous one
// has been loaded into the output register, so only one is in flight at a time.
// After reset the slot memory is cleared one entry per cycle, with in_ready
// held low.
// A lookup miss returns hit=0 and zero data; the caller fetches the block and
// fills the slot with a store, which reports whether a different block was
// evicted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hashed_direct_mapped_block_cache_core #(
    parameter int TABLE_SLOTS = 301,
    parameter int DATA_BITS   = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               req_type,
    input  logic [hdmc_pkg::KEY_BITS-1:0]      block_number,
    input  logic [hdmc_pkg::DATA_PORT_W-1:0]   block_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               hit,
    output logic [hdmc_pkg::DATA_PORT_W-1:0]   read_data,
    output logic                               replaced_other
);

    hdmc_pkg::cmd_t cmd;
    hdmc_pkg::sts_t sts;

    // Controller
    hdmc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath
    hdmc_dp #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .DATA_BITS   (DATA_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .req_type       (req_type),
        .block_number   (block_number),
        .block_data     (block_data),
        .hit            (hit),
        .read_data      (read_data),
        .replaced_other (replaced_other)
    );

    // One request in flight at a time
    a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while another is in flight");

    // No request taken during the clearing pass
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_we |-> !in_ready)
        else $error("request accepted during clearing pass");

    // A finished request shows up as a valid response
    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid)
        else $error("response not presented after finish");

    // A hit never reports an eviction
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(hit && replaced_other))
        else $error("hit and replaced_other both set");

endmodule

// ===== tb/sv/hdmc_cache_checker.sv =====
// ----------------------------------------------------------------------------
// hdmc_cache_checker
// Watches the request and response channels of the block cache core and keeps its own
// copy of the slot table. Every accepted request is run through that table to
// give the expected response. Each response the core hands over is compared
// field by field with the oldest expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hdmc_cache_checker #(
    parameter int SLOT_COUNT = 301,
    parameter int DATA_BITS  = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic                               req_type,
    input  logic [hdmc_pkg::KEY_BITS-1:0]      block_number,
    input  logic [hdmc_pkg::DATA_PORT_W-1:0]   block_data,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic                               hit,
    input  logic [hdmc_pkg::DATA_PORT_W-1:0]   read_data,
    input  logic                               replaced_other,
    output int                                 mismatch_count,
    output int                                 outstanding
);

    localparam logic [31:0] SLOT_MULT = 32'd754343;
    localparam logic [hdmc_pkg::DATA_PORT_W-1:0] DATA_KEEP =
        {hdmc_pkg::DATA_PORT_W{1'b1}} >> (hdmc_pkg::DATA_PORT_W - DATA_BITS);

    typedef struct packed {
        logic                             hit;
        logic [hdmc_pkg::DATA_PORT_W-1:0] read_data;
        logic                             replaced_other;
    } cache_response_t;

    // Local copy of the slot table
    bit                               slot_used [SLOT_COUNT];
    logic [hdmc_pkg::KEY_BITS-1:0]    slot_key  [SLOT_COUNT];
    logic [hdmc_pkg::DATA_PORT_W-1:0] slot_word [SLOT_COUNT];

    cache_response_t awaited_responses [$];
    int              errors = 0;

    // Multiply with 32-bit wraparound, take the signed magnitude, reduce
    function automatic int unsigned hashed_slot(logic [hdmc_pkg::KEY_BITS-1:0] key);
        logic [31:0] product;
        logic [31:0] magnitude;
        product   = {1'b0, key} * SLOT_MULT;
        magnitude = product[31] ? (32'd0 - product) : product;
        return magnitude % SLOT_COUNT;
    endfunction

    // Apply one request to the table and return the response it should give
    function automatic cache_response_t apply_cache_request(
        logic                             kind,
        logic [hdmc_pkg::KEY_BITS-1:0]    key,
        logic [hdmc_pkg::DATA_PORT_W-1:0] word
    );
        cache_response_t r;
        int unsigned     s;
        logic            tag_match;
        s         = hashed_slot(key);
        tag_match = slot_used[s] && (slot_key[s] == key);
        r         = '0;
        r.hit     = tag_match;
        if (kind == hdmc_pkg::REQ_STORE)
        begin
            r.replaced_other = slot_used[s] && !tag_match;
            slot_used[s]     = 1'b1;
            slot_key[s]      = key;
            slot_word[s]     = word & DATA_KEEP;
        end
        else if (tag_match)
        begin
            r.read_data = slot_word[s];
        end
        return r;
    endfunction

    // Predict on input acceptance, compare on output acceptance
    always @(posedge clk or negedge rst_n)
    begin
        cache_response_t want;
        cache_response_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slot_used[i] = 1'b0;
                slot_key[i]  = '0;
                slot_word[i] = '0;
            end
            awaited_responses.delete();
            errors = 0;
            mismatch_count <= 0;
            outstanding    <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                awaited_responses.push_back(
                    apply_cache_request(req_type, block_number, block_data));

            if (out_valid && out_ready)
            begin
                got = '{hit: hit, read_data: read_data, replaced_other: replaced_other};
                if (awaited_responses.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display({"%0t: response with no request outstanding:",
                                  " hit=%b data=%h repl=%b"},
                                 $realtime, got.hit, got.read_data,
                                 got.replaced_other);
                end
                else
                begin
                    want = awaited_responses.pop_front();
                    if (got.hit !== want.hit || got.read_data !== want.read_data ||
                        got.replaced_other !== want.replaced_other)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"%0t: mismatch: expected hit=%b data=%h repl=%b,",
                                      " got hit=%b data=%h repl=%b"},
                                     $realtime, want.hit, want.read_data,
                                     want.replaced_other, got.hit, got.read_data,
                                     got.replaced_other);
                    end
                end
            end

            mismatch_count <= errors;
            outstanding    <= awaited_responses.size();
        end
    end

endmodule

// ===== tb/sv/hashed_direct_mapped_block_cache_core_test.sv =====
// ----------------------------------------------------------------------------
// hashed_direct_mapped_block_cache_core_test
// Drives lookup and store requests into the block cache core. A directed run
// comes first: empty slots, a hit in slot zero, collisions, stores on a hit and
// the extreme block numbers. Random traffic follows over a small pool of block
// numbers so that hits and evictions are common. The phases change the idling
// of both sides, and one long output hold-off fills the core. The checker
// reports the mismatches.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hashed_direct_mapped_block_cache_core_test;

    localparam int SLOTS          = 301;
    localparam int POOL_SIZE      = 48;
    localparam int REQS_PER_PHASE = 500;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_LIMIT    = 20000;

    logic                             clk            = 1'b0;
    logic                             rst_n          = 1'b0;
    logic                             in_valid       = 1'b0;
    logic                             in_ready;
    logic                             req_type       = hdmc_pkg::REQ_LOOKUP;
    logic [hdmc_pkg::KEY_BITS-1:0]    block_number   = '0;
    logic [hdmc_pkg::DATA_PORT_W-1:0] block_data     = '0;
    logic                             out_valid;
    logic                             out_ready      = 1'b0;
    logic                             hit;
    logic [hdmc_pkg::DATA_PORT_W-1:0] read_data;
    logic                             replaced_other;

    int mismatch_count;
    int outstanding;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_ticket   = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    logic [hdmc_pkg::KEY_BITS-1:0] key_pool [POOL_SIZE];

    hashed_direct_mapped_block_cache_core #(
        .TABLE_SLOTS (SLOTS),
        .DATA_BITS   (64)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .block_number   (block_number),
        .block_data     (block_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .hit            (hit),
        .read_data      (read_data),
        .replaced_other (replaced_other)
    );

    hdmc_cache_checker #(
        .SLOT_COUNT (SLOTS),
        .DATA_BITS  (64)
    ) checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .block_number   (block_number),
        .block_data     (block_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .hit            (hit),
        .read_data      (read_data),
        .replaced_other (replaced_other),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop
    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Response side: random stalls, plus a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_ticket != hold_served)
        begin
            hold_served <= hold_ticket;
            hold_left   <= LONG_HOLD;
            out_ready   <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offer one request and wait until it is taken
    task automatic send_request(
        input logic                             kind,
        input logic [hdmc_pkg::KEY_BITS-1:0]    key,
        input logic [hdmc_pkg::DATA_PORT_W-1:0] word
    );
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= kind;
        block_number <= key;
        block_data   <= word;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    function automatic logic [hdmc_pkg::KEY_BITS-1:0] pick_block();
        logic [31:0] raw;
        raw = $urandom();
        if ($urandom_range(99) < 80)
            return key_pool[$urandom_range(POOL_SIZE - 1)];
        return raw[hdmc_pkg::KEY_BITS-1:0];
    endfunction

    function automatic logic [hdmc_pkg::DATA_PORT_W-1:0] pick_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // Stimulus
    initial
    begin
        logic [hdmc_pkg::KEY_BITS-1:0] max_key;
        logic [31:0]                   raw_key;
        int                            waited;
        max_key = '1;

        // Pool: four blocks sharing slot zero, the largest number, the rest random
        key_pool[0] = 31'd0;
        key_pool[1] = 31'd301;
        key_pool[2] = 31'd602;
        key_pool[3] = 31'd903;
        key_pool[4] = max_key;
        for (int i = 5; i < POOL_SIZE; i++)
        begin
            raw_key     = $urandom();
            key_pool[i] = raw_key[hdmc_pkg::KEY_BITS-1:0];
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty slot, hit in slot zero, collisions, store on a hit
        send_request(hdmc_pkg::REQ_LOOKUP, 31'd0, '1);
        send_request(hdmc_pkg::REQ_STORE,  31'd0, '1);
        send_request(hdmc_pkg::REQ_LOOKUP, 31'd0, '0);
        send_request(hdmc_pkg::REQ_STORE,  31'd0, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(hdmc_pkg::REQ_LOOKUP, 31'd0, '0);
        send_request(hdmc_pkg::REQ_LOOKUP, 31'd301, '0);
        send_request(hdmc_pkg::REQ_STORE,  31'd301, 64'h5555_5555_5555_5555);
        send_request(hdmc_pkg::REQ_LOOKUP, 31'd0, '0);
        send_request(hdmc_pkg::REQ_LOOKUP, 31'd301, '1);
        send_request(hdmc_pkg::REQ_STORE,  31'd602, '0);
        send_request(hdmc_pkg::REQ_LOOKUP, 31'd602, '0);
        // Largest block number: the product stays positive before the magnitude
        send_request(hdmc_pkg::REQ_LOOKUP, max_key, '0);
        send_request(hdmc_pkg::REQ_STORE,  max_key, 64'h8000_0000_0000_0001);
        send_request(hdmc_pkg::REQ_LOOKUP, max_key, 64'h0123_4567_89AB_CDEF);
        send_request(hdmc_pkg::REQ_STORE,  max_key, 64'h7FFF_FFFF_FFFF_FFFE);
        send_request(hdmc_pkg::REQ_LOOKUP, max_key, '0);
        send_request(hdmc_pkg::REQ_STORE,  31'h4000_0000, 64'hFFFF_FFFF_0000_0000);
        send_request(hdmc_pkg::REQ_LOOKUP, 31'h4000_0000, '0);
        send_request(hdmc_pkg::REQ_STORE,  31'h2AAA_AAAA, 64'h0000_0000_FFFF_FFFF);
        send_request(hdmc_pkg::REQ_LOOKUP, 31'h2AAA_AAAA, '0);
        send_request(hdmc_pkg::REQ_LOOKUP, 31'h5555_5555, '0);

        // Random phases with different idling on each side
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin send_idle_pct = 0;  stall_pct <= 0;  end
                1:       begin send_idle_pct = 71; stall_pct <= 0;  end
                2:       begin send_idle_pct = 0;  stall_pct <= 71; end
                default: begin send_idle_pct = 17; stall_pct <= 17; end
            endcase
            // Hold off responses while requests keep coming
            if (ph == 0)
                hold_ticket <= hold_ticket + 1;
            for (int n = 0; n < REQS_PER_PHASE; n++)
                send_request(($urandom_range(99) < 45) ? hdmc_pkg::REQ_STORE
                                                       : hdmc_pkg::REQ_LOOKUP,
                             pick_block(), pick_word());
        end
        in_valid <= 1'b0;
        // let the checker count the last request before draining
        @(posedge clk);

        // Drain
        waited = 0;
        while (outstanding != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (outstanding != 0)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            repeat (16) @(posedge clk);
            if (mismatch_count == 0)
                $display("Test completed successfully");
            else
                $display("Test completed with failures");
            $finish;
        end
    end

endmodule
